// ----- hw/rtl/skvd_pkg.sv -----
// Shared types and constants for the sparse keyed vector dot product core.
`timescale 1ns / 1ps

package skvd_pkg;

  // Field widths of the item channels
  localparam int OP_W   = 2;
  localparam int KEY_W  = 7;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int CT_W   = 4;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 48;

  // Saturation limits of the Q18.30 accumulator
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_ELEM_B = 2'd2
  } op_e;

  // Core sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ACC
  } state_e;

endpackage

// ----- hw/rtl/skvd_in_if.sv -----
// Input item channel: opcode, key, index, value, center type and last flag.
`timescale 1ns / 1ps

interface skvd_in_if
  import skvd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [KEY_W-1:0]        key;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic [CT_W-1:0]         center_type;
  logic                    last;

  modport source (
    output valid, op, key, index, value, center_type, last,
    input  ready
  );

  modport sink (
    input  valid, op, key, index, value, center_type, last,
    output ready
  );
endinterface

// ----- hw/rtl/skvd_out_if.sv -----
// Result item channel: saturated dot product and filter flag.
`timescale 1ns / 1ps

interface skvd_out_if
  import skvd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] dot_value;
  logic                    filtered_out;

  modport source (
    output valid, dot_value, filtered_out,
    input  ready
  );

  modport sink (
    input  valid, dot_value, filtered_out,
    output ready
  );
endinterface

// ----- hw/rtl/skvd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module skvd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sparse_keyed_vector_dot_core.sv -----
// Top level of the sparse keyed vector dot product core.
//
// Usage: map A is loaded with OP_LOAD_A items (key, index, value, center
// type); each one is written to the coefficient RAM and marks its key.
// Map B then streams in as OP_ELEM_B items; an item whose key is marked
// multiplies its value with the stored A coefficient and adds the product
// to a saturating 48-bit Q18.30 accumulator. The B item flagged last emits
// one result item and clears the accumulator. OP_CLEAR drops all key marks.
// With the filter bit set, a center type mismatch between the last B item
// and the last loaded A item forces a zero result with filtered_out high.
// Clear, load and unused opcodes are taken in the idle state; a B item
// goes through RAM read, registered multiply and accumulate before a new
// item is taken. A last B item loads its result in the accumulate step.
// A waiting result does not stop the core; only the next last B item
// waits in the accumulate step until the output register is free.
// Reset clears key marks, accumulator, center type, filter bit and the
// output valid; RAM contents stay undefined until written.
`timescale 1ns / 1ps

module sparse_keyed_vector_dot_core
  import skvd_pkg::*;
#(
  parameter int KEYS    = 128,
  parameter int VEC_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  skvd_in_if.sink     in_i,
  skvd_out_if.source  out_o
);

  localparam int DEPTH = KEYS * VEC_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = AW + KEY_W + IDX_W;
  // Only keys the key field can carry need a mark
  localparam int VN    = (KEYS < (2 ** KEY_W)) ? KEYS : (2 ** KEY_W);
  localparam int VI_W  = $clog2(VN);

  state_e                   state_q, state_d;
  logic [VN-1:0]            key_valid_q, key_valid_d;
  logic [CT_W-1:0]          a_center_q, a_center_d;
  logic                     filter_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0]  dot_q, dot_d;
  logic                     filt_q, filt_d;
  logic                     hit_q, hit_d;
  logic signed [VAL_W-1:0]  b_val_q, b_val_d;
  logic [CT_W-1:0]          b_ctype_q, b_ctype_d;
  logic                     b_last_q, b_last_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                     in_ready;
  logic                     in_range;
  logic [VI_W-1:0]          vidx;
  logic [WW-1:0]            addr_wide;
  logic [AW-1:0]            addr;
  logic                     ram_we;
  logic                     ram_re;
  logic signed [VAL_W-1:0]  a_rdata;
  logic signed [PROD_W-1:0] mult;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sat_sum;
  logic                     can_load;
  logic                     mismatch;

  // Store address and range check of the incoming item
  assign addr_wide = WW'(in_i.key) * WW'(VEC_LEN) + WW'(in_i.index);
  assign addr      = addr_wide[AW-1:0];
  assign in_range  = (32'(in_i.key) < 32'(KEYS)) && (32'(in_i.index) < 32'(VEC_LEN));
  assign vidx      = in_i.key[VI_W-1:0];

  skvd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (a_rdata)
  );

  // Multiply and saturating accumulate
  assign mult    = a_rdata * b_val_q;
  assign sum     = {acc_q[ACC_W-1], acc_q} + (ACC_W + 1)'(prod_q);
  assign sat_sum = (sum[ACC_W] != sum[ACC_W-1]) ? (sum[ACC_W] ? ACC_MIN : ACC_MAX)
                                                : sum[ACC_W-1:0];
  assign can_load = !out_valid_q || out_o.ready;
  assign mismatch = filter_q && (b_ctype_q != a_center_q);

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    key_valid_d = key_valid_q;
    a_center_d  = a_center_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    dot_d       = dot_q;
    filt_d      = filt_q;
    hit_d       = hit_q;
    b_val_d     = b_val_q;
    b_ctype_d   = b_ctype_q;
    b_last_d    = b_last_q;
    prod_d      = prod_q;
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          unique case (in_i.op)
            OP_CLEAR: begin
              key_valid_d = '0;
            end
            OP_LOAD_A: begin
              if (in_range) begin
                ram_we            = 1'b1;
                key_valid_d[vidx] = 1'b1;
              end
              a_center_d = in_i.center_type;
            end
            OP_ELEM_B: begin
              ram_re    = 1'b1;
              hit_d     = in_range && key_valid_q[vidx];
              b_val_d   = in_i.value;
              b_ctype_d = in_i.center_type;
              b_last_d  = in_i.last;
              state_d   = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // RAM data is valid now; unmarked or out-of-range keys add nothing
        prod_d  = hit_q ? mult : '0;
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!b_last_q) begin
          acc_d   = sat_sum;
          state_d = S_IDLE;
        end else if (can_load) begin
          out_valid_d = 1'b1;
          dot_d       = mismatch ? '0 : sat_sum;
          filt_d      = mismatch;
          acc_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_valid_q <= '0;
      a_center_q  <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      filter_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_valid_q <= key_valid_d;
      a_center_q  <= a_center_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        filter_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dot_q     <= dot_d;
    filt_q    <= filt_d;
    hit_q     <= hit_d;
    b_val_q   <= b_val_d;
    b_ctype_q <= b_ctype_d;
    b_last_q  <= b_last_d;
    prod_q    <= prod_d;
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.dot_value    = dot_q;
  assign out_o.filtered_out = filt_q;

  // A new result only comes from the accumulate step of a last B item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_ACC && b_last_q))
    else $error("result without a last B item");

  // The accumulator is empty after a result was emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && b_last_q && can_load) |=> (acc_q == '0))
    else $error("accumulator not cleared after result");

  // A filtered result carries a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.filtered_out) |-> (out_o.dot_value == '0))
    else $error("filtered result is not zero");

  // The RAM read of a B item always precedes its multiply step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(ram_re))
    else $error("multiply step without RAM read");

endmodule

// ----- sim/sparse_keyed_vector_dot_core_tb.sv -----
// Self-checking testbench for the sparse keyed vector dot product core.
`timescale 1ns / 1ps

module sparse_keyed_vector_dot_core_tb;
  import skvd_pkg::*;

  localparam int  KEYS         = 128;
  localparam int  VEC_LEN      = 64;
  localparam int  RAND_ITEMS   = 380;
  localparam int  HOLD_CYCLES  = 200;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  MAX_PRINTS   = 40;
  localparam int  DIR_ROWS     = 18;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One input item as driven on the channel
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [KEY_W-1:0]        key;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic [CT_W-1:0]         ct;
    logic                    last;
  } elem_t;

  // One result item
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic                    filt;
  } dot_res_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // Directed row: an item or a filter write, with an optional typed-in result
  typedef struct {
    row_kind_e          kind;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   value;
    logic [CT_W-1:0]    ct;
    bit                 last;
    bit                 cfg_val;
    bit                 typed;
    logic [ACC_W-1:0]   dot;
    bit                 filt;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  skvd_in_if  in_if ();
  skvd_out_if out_if ();

  sparse_keyed_vector_dot_core #(
    .KEYS    (KEYS),
    .VEC_LEN (VEC_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state
  logic signed [VAL_W-1:0] coef_mem     [KEYS*VEC_LEN];
  bit                      coef_written [KEYS*VEC_LEN];
  bit                      key_mark     [KEYS];
  logic [CT_W-1:0]         a_ct      = '0;
  logic signed [ACC_W-1:0] dot_acc   = '0;
  bit                      filter_on = 1'b0;

  dot_res_t pending_dots [$];
  int       mismatches = 0;
  int       items_sent = 0;
  bit       gaps_on    = 1'b1;
  bit       hold_req   = 1'b0;

  // Directed stimulus
  dir_row_t dir_tab [DIR_ROWS] = '{
    // nothing marked after reset
    '{ROW_ITEM, OP_ELEM_B,  7'd5,   6'd0,  16'h7FFF, 4'd0, 1, 0, 1, 48'sd0, 0},
    // extremes of value, key and index; last ignored on a load
    '{ROW_ITEM, OP_LOAD_A,  7'd0,   6'd0,  16'h8000, 4'd3, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_LOAD_A,  7'd127, 6'd63, 16'h7FFF, 4'd3, 1, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd0,  16'h8000, 4'd3, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd127, 6'd63, 16'h7FFF, 4'd3, 1, 0, 1,
      48'sd2147418113, 0},
    // unused opcode, even with last set
    '{ROW_ITEM, OP_UNUSED,  7'd0,   6'd0,  16'h0000, 4'd0, 1, 0, 0, 48'sd0, 0},
    '{ROW_CFG,  OP_CLEAR,   7'd0,   6'd0,  16'h0000, 4'd0, 0, 1, 0, 48'sd0, 0},
    // center type mismatch with filter on, then a match
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd0,  16'h0001, 4'd5, 1, 0, 1, 48'sd0, 1},
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd0,  16'h0001, 4'd3, 1, 0, 1, -48'sd32768, 0},
    // clear drops marks; old coefficients survive a clear
    '{ROW_ITEM, OP_CLEAR,   7'd0,   6'd0,  16'h0000, 4'd0, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd0,  16'h7FFF, 4'd3, 1, 0, 1, 48'sd0, 0},
    '{ROW_ITEM, OP_LOAD_A,  7'd0,   6'd1,  16'h1234, 4'd9, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd0,  16'h8000, 4'd9, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd1,  16'hFFFF, 4'd9, 1, 0, 0, 48'sd0, 0},
    '{ROW_CFG,  OP_CLEAR,   7'd0,   6'd0,  16'h0000, 4'd0, 0, 0, 0, 48'sd0, 0},
    // mismatch with filter off passes the sum
    '{ROW_ITEM, OP_ELEM_B,  7'd0,   6'd1,  16'h0001, 4'd2, 1, 0, 1, 48'sd4660, 0},
    // unmarked keys add nothing
    '{ROW_ITEM, OP_ELEM_B,  7'd64,  6'd5,  16'h7FFF, 4'd9, 0, 0, 0, 48'sd0, 0},
    '{ROW_ITEM, OP_ELEM_B,  7'd127, 6'd63, 16'h0001, 4'd9, 1, 0, 1, 48'sd0, 0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advance the predictor by one accepted item
  function automatic void predict_elem(input elem_t e, output bit has_res,
                                       output dot_res_t res);
    int     addr;
    longint sum;
    // key and index widths match KEYS and VEC_LEN, so every address is in range
    addr    = int'(e.key) * VEC_LEN + int'(e.idx);
    has_res = 1'b0;
    res     = '0;
    case (e.op)
      OP_CLEAR: key_mark = '{default: 1'b0};
      OP_LOAD_A: begin
        coef_mem[addr]     = e.value;
        coef_written[addr] = 1'b1;
        key_mark[e.key]    = 1'b1;
        a_ct               = e.ct;
      end
      OP_ELEM_B: begin
        if (key_mark[e.key]) begin
          sum = longint'(dot_acc) + longint'(coef_mem[addr]) * longint'($signed(e.value));
          if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
          if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
          dot_acc = sum[ACC_W-1:0];
        end
        if (e.last) begin
          has_res  = 1'b1;
          res.filt = filter_on && (e.ct != a_ct);
          res.dot  = res.filt ? '0 : dot_acc;
          dot_acc  = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Steer a B item off a marked key's never-loaded index
  function automatic logic [IDX_W-1:0] safe_index(input logic [KEY_W-1:0] k,
                                                  input logic [IDX_W-1:0] i);
    int base;
    int probe;
    base = int'(k) * VEC_LEN;
    if (!key_mark[k] || coef_written[base + int'(i)]) return i;
    for (int n = 0; n < VEC_LEN; n++) begin
      probe = (int'(i) + n) % VEC_LEN;
      if (coef_written[base + probe]) return IDX_W'(probe);
    end
    return i;
  endfunction

  function automatic logic [VAL_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Offer one item from a falling edge, return at the falling edge after acceptance
  task automatic push_item(input elem_t e, input bit typed, input dot_res_t typed_res);
    bit       has_res;
    dot_res_t res;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      in_if.value = VAL_W'($urandom);
      in_if.key   = KEY_W'($urandom);
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.op          = e.op;
    in_if.key         = e.key;
    in_if.index       = e.idx;
    in_if.value       = e.value;
    in_if.center_type = e.ct;
    in_if.last        = e.last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_elem(e, has_res, res);
    if (has_res) pending_dots.insert(pending_dots.size(), typed ? typed_res : res);
    if (e.op != OP_UNUSED) items_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Wait until every result is out and the core has settled
  task automatic wait_drained();
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_filter(input bit v);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    filter_on = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Load a small map A, then stream a map B ending in last
  task automatic send_map_pair();
    int               n_a;
    int               n_b;
    int               pick;
    logic [CT_W-1:0]  map_ct;
    logic [KEY_W-1:0] keys_a [$];
    logic [IDX_W-1:0] idxs_a [$];
    elem_t            e;
    n_a    = $urandom_range(1, 8);
    n_b    = $urandom_range(1, 10);
    map_ct = CT_W'($urandom);
    e      = '0;
    if ($urandom_range(0, 3) == 0) begin
      e.op  = OP_CLEAR;
      e.key = KEY_W'($urandom);
      push_item(e, 1'b0, '0);
    end
    for (int j = 0; j < n_a; j++) begin
      e.op    = OP_LOAD_A;
      e.key   = $urandom_range(0, 1) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 7));
      e.idx   = IDX_W'($urandom);
      e.value = rand_coef();
      e.ct    = ($urandom_range(0, 7) == 0) ? CT_W'($urandom) : map_ct;
      e.last  = 1'($urandom);
      keys_a.insert(keys_a.size(), e.key);
      idxs_a.insert(idxs_a.size(), e.idx);
      push_item(e, 1'b0, '0);
    end
    for (int j = 0; j < n_b; j++) begin
      e.op = OP_ELEM_B;
      if ($urandom_range(0, 9) < 7) begin
        pick  = $urandom_range(0, keys_a.size() - 1);
        e.key = keys_a[pick];
        e.idx = idxs_a[pick];
      end else begin
        e.key = KEY_W'($urandom);
        e.idx = IDX_W'($urandom);
      end
      e.idx   = safe_index(e.key, e.idx);
      e.value = rand_coef();
      e.ct    = ($urandom_range(0, 3) == 0) ? CT_W'($urandom) : a_ct;
      e.last  = (j == n_b - 1);
      push_item(e, 1'b0, '0);
    end
  endtask

  // Fully random item, any opcode
  task automatic send_noise();
    logic [63:0] raw;
    elem_t       e;
    raw = {$urandom, $urandom};
    e   = raw[$bits(elem_t)-1:0];
    if (e.op == OP_ELEM_B) e.idx = safe_index(e.key, e.idx);
    push_item(e, 1'b0, '0);
  endtask

  // Result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req     = 1'b0;
        out_if.ready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        stall        = $urandom_range(1, 7);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    dot_res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_dots.size() == 0) begin
        report_mismatch($sformatf("unexpected result dot=%0d filt=%0b",
                                  out_if.dot_value, out_if.filtered_out));
      end else begin
        want = pending_dots.pop_front();
        if (out_if.dot_value !== want.dot)
          report_mismatch($sformatf("dot_value got %0d want %0d",
                                    out_if.dot_value, want.dot));
        if (out_if.filtered_out !== want.filt)
          report_mismatch($sformatf("filtered_out got %b want %b",
                                    out_if.filtered_out, want.filt));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    elem_t    e;
    dot_res_t want;
    int       seq_no;
    int       start_items;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    in_if.valid       = 1'b0;
    in_if.op          = '0;
    in_if.key         = '0;
    in_if.index       = '0;
    in_if.value       = '0;
    in_if.center_type = '0;
    in_if.last        = 1'b0;
    key_mark          = '{default: 1'b0};
    coef_written      = '{default: 1'b0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_filter(dir_tab[r].cfg_val);
      end else begin
        e.op      = dir_tab[r].op;
        e.key     = dir_tab[r].key;
        e.idx     = dir_tab[r].idx;
        e.value   = dir_tab[r].value;
        e.ct      = dir_tab[r].ct;
        e.last    = dir_tab[r].last;
        want.dot  = dir_tab[r].dot;
        want.filt = dir_tab[r].filt;
        push_item(e, dir_tab[r].typed, want);
      end
    end

    // random map pairs with noise, filter changes and one long sink hold-off
    seq_no      = 0;
    start_items = items_sent;
    while (items_sent - start_items < RAND_ITEMS) begin
      if (seq_no == 6) hold_req = 1'b1;
      if (seq_no % 10 == 9) write_filter(1'($urandom));
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_noise();
      else send_map_pair();
      seq_no++;
    end

    // back-to-back tail
    gaps_on = 1'b0;
    write_filter(1'b1);
    repeat (3) send_map_pair();
    write_filter(1'b0);
    repeat (2) send_map_pair();

    wait_drained();
    if (mismatches == 0 && pending_dots.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
